// ----- hw/rtl/sdl_pkg.sv -----
`default_nettype none

package sdl_pkg;

   localparam int PIX_W     = 8;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DISP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT  = 3'd4;

   localparam logic [10:0] RST_WIDTH  = 11'd640;
   localparam logic [12:0] RST_HEIGHT = 13'd480;
   localparam logic [2:0]  RST_HALF   = 3'd3;
   localparam logic [6:0]  RST_DISP   = 7'd32;
   localparam logic [15:0] RST_LIMIT  = 16'd512;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SCAN,
      ST_FIN
   } state_type;

   // controls broadcast along the cost chain
   typedef struct packed {
      logic clear;
      logic shift;
      logic take;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ssd_stereo_disparity_left.sv -----
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  left_pixel, right_pixel
// rsp       out  rsp_valid/rsp_stall  disparity, out_row, out_col, interior, match_found,
//                                     frame_end
// csr       in   csr_write            csr_index, csr_data
// One request at a time. When no result is due, a request goes through accept and decide only.
// Border pixel: accept, decide and finish, where finish waits for the output.
// Interior pixel: accept and decide, then window reads over 2h+1 rows, one line store read
// per cycle, then drain, shifting the nd costs out of the chain, and finish.
// Synchronous reset clears counters and control; line stores are not cleared.
// A held result does not block the next request; rsp_stall only holds the finish step.

`default_nettype none

module ssd_stereo_disparity_left #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_HALF   = 7,
   parameter int MAX_DISP   = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [7:0]                       req_left_pixel,
   input  wire [7:0]                       req_right_pixel,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [5:0]                      rsp_disparity,
   output logic [11:0]                     rsp_out_row,
   output logic [9:0]                      rsp_out_col,
   output logic                            rsp_interior,
   output logic                            rsp_match_found,
   output logic                            rsp_frame_end,
   input  wire                             csr_write,
   input  wire [sdl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [sdl_pkg::CSR_W-1:0]        csr_data
);
   import sdl_pkg::*;

   localparam int ROWS_KEPT = 2 * MAX_HALF + 1;
   localparam int DEPTH     = ROWS_KEPT * MAX_WIDTH;
   localparam int AW        = $clog2(DEPTH);
   localparam int RK_W      = $clog2(ROWS_KEPT);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int WV_W      = $clog2(MAX_WIDTH + 1);
   localparam int HV_W      = $clog2(MAX_HEIGHT + 1);
   localparam int H_W       = $clog2(MAX_HALF + 1);
   localparam int ND_W      = $clog2(MAX_DISP + 1);
   localparam int D_W       = $clog2(MAX_DISP);
   localparam int SD_W      = $clog2(ROWS_KEPT + 1);
   localparam int SQ_W      = $clog2(ROWS_KEPT * ROWS_KEPT + 1);
   localparam int ACC_W     = 16 + SQ_W;
   localparam int LAG_W     = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 1);
   localparam int XS_W      = ((COL_W > D_W) ? COL_W : D_W) + 2;

   state_type state_ff, state_in;

   logic [10:0] wreg_ff, wreg_in;
   logic [12:0] hreg_ff, hreg_in;
   logic [2:0]  halfreg_ff, halfreg_in;
   logic [6:0]  ndreg_ff, ndreg_in;
   logic [15:0] limreg_ff, limreg_in;

   logic [WV_W-1:0] w_cl;
   logic [HV_W-1:0] hgt_cl;
   logic [H_W-1:0]  half_cl;
   logic [ND_W-1:0] nd_cl;
   logic [SD_W-1:0] side;

   logic [SQ_W-1:0]  side_sq_ff, side_sq_in;
   logic [ACC_W-1:0] limit_ff, limit_in;
   logic [LAG_W-1:0] lag_ff, lag_in;
   logic [LAG_W-1:0] pend_ff, pend_in;

   logic [COL_W-1:0] col_ff, col_in, ocol_ff, ocol_in, cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] row_ff, row_in, orow_ff, orow_in, cur_row_ff, cur_row_in;
   logic [RK_W-1:0]  rslot_ff, rslot_in, oslot_ff, oslot_in;
   logic             interior_ff, interior_in, last_ff, last_in;

   logic signed [XS_W-1:0] xs_ff, xs_in, xe_ff, xe_in, xl_ff, xl_in, ix_ff, ix_in;
   logic [RK_W-1:0]        iy_ff, iy_in, islot_ff, islot_in;
   logic                   flag1_ff, flag1_in, flag2_ff;
   logic [7:0]             left_ff;
   logic [1:0]             drain_ff, drain_in;
   logic [D_W-1:0]         sd_ff, sd_in, bdisp_ff, bdisp_in;
   logic [ACC_W-1:0]       best_ff, best_in;
   logic                   found_ff, found_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_disp_ff, rsp_disp_in;
   logic [11:0] rsp_row_ff, rsp_row_in;
   logic [9:0]  rsp_col_ff, rsp_col_in;
   logic        rsp_int_ff, rsp_int_in, rsp_match_ff, rsp_match_in, rsp_end_ff, rsp_end_in;

   logic            accept;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [7:0]      ram_left_q, ram_right_q;
   cell_ctl_type    ctl;
   logic [7:0]       right_q [MAX_DISP];
   logic [ACC_W-1:0] acc_q   [MAX_DISP];

   function automatic logic [AW-1:0] slot_addr(input logic [RK_W-1:0] s,
                                                input logic [COL_W-1:0] c);
      slot_addr = AW'(s) * AW'(MAX_WIDTH) + AW'(c);
   endfunction

   // settings clamped to their legal ranges
   always_comb begin
      w_cl    = (wreg_ff == '0) ? WV_W'(1) :
                (int'(wreg_ff) > MAX_WIDTH) ? WV_W'(MAX_WIDTH) : WV_W'(wreg_ff);
      hgt_cl  = (hreg_ff == '0) ? HV_W'(1) :
                (int'(hreg_ff) > MAX_HEIGHT) ? HV_W'(MAX_HEIGHT) : HV_W'(hreg_ff);
      half_cl = (int'(halfreg_ff) > MAX_HALF) ? H_W'(MAX_HALF) : H_W'(halfreg_ff);
      nd_cl   = (ndreg_ff == '0) ? ND_W'(1) :
                (int'(ndreg_ff) > MAX_DISP) ? ND_W'(MAX_DISP) : ND_W'(ndreg_ff);
      side       = SD_W'(2 * int'(half_cl) + 1);
      side_sq_in = SQ_W'(SQ_W'(side) * SQ_W'(side));
      limit_in   = ACC_W'(limreg_ff) * ACC_W'(side_sq_ff);
      lag_in     = LAG_W'(half_cl) * LAG_W'(w_cl) + LAG_W'(half_cl);
   end

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign wr_addr   = slot_addr(rslot_ff, col_ff);
   assign rd_addr   = slot_addr(islot_ff, ix_ff[XS_W-1] ? '0 : ix_ff[COL_W-1:0]);

   always_comb begin
      state_in   = state_ff;
      wreg_in    = wreg_ff;
      hreg_in    = hreg_ff;
      halfreg_in = halfreg_ff;
      ndreg_in   = ndreg_ff;
      limreg_in  = limreg_ff;
      pend_in    = pend_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      rslot_in   = rslot_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      oslot_in   = oslot_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      interior_in = interior_ff;
      last_in    = last_ff;
      xs_in      = xs_ff;
      xe_in      = xe_ff;
      xl_in      = xl_ff;
      ix_in      = ix_ff;
      iy_in      = iy_ff;
      islot_in   = islot_ff;
      flag1_in   = 1'b0;
      drain_in   = drain_ff;
      sd_in      = sd_ff;
      bdisp_in   = bdisp_ff;
      best_in    = best_ff;
      found_in   = found_ff;
      ctl        = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_disp_in  = rsp_disp_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_int_in   = rsp_int_ff;
      rsp_match_in = rsp_match_ff;
      rsp_end_in   = rsp_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
               if (int'(col_ff) + 1 >= int'(w_cl)) begin
                  col_in = '0;
                  if (int'(row_ff) + 1 >= int'(hgt_cl)) begin
                     row_in   = '0;
                     rslot_in = '0;
                  end else begin
                     row_in   = row_ff + ROW_W'(1);
                     rslot_in = (int'(rslot_ff) == ROWS_KEPT - 1) ? '0 : rslot_ff + RK_W'(1);
                  end
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         ST_DECIDE: begin
            if (pend_ff < lag_ff) begin
               pend_in  = pend_ff + LAG_W'(1);
               state_in = ST_IDLE;
            end else begin
               ctl.clear   = 1'b1;
               cur_col_in  = ocol_ff;
               cur_row_in  = orow_ff;
               interior_in = (int'(orow_ff) >= int'(half_cl)) &&
                             (int'(orow_ff) + int'(half_cl) < int'(hgt_cl)) &&
                             (int'(ocol_ff) >= int'(half_cl)) &&
                             (int'(ocol_ff) + int'(half_cl) < int'(w_cl));
               last_in     = (int'(orow_ff) + 1 >= int'(hgt_cl)) &&
                             (int'(ocol_ff) + 1 >= int'(w_cl));
               if (int'(ocol_ff) + 1 >= int'(w_cl)) begin
                  ocol_in = '0;
                  if (int'(orow_ff) + 1 >= int'(hgt_cl)) begin
                     orow_in  = '0;
                     oslot_in = '0;
                  end else begin
                     orow_in  = orow_ff + ROW_W'(1);
                     oslot_in = (int'(oslot_ff) == ROWS_KEPT - 1) ? '0 : oslot_ff + RK_W'(1);
                  end
               end else begin
                  ocol_in = ocol_ff + COL_W'(1);
               end
               xs_in    = XS_W'(ocol_ff) - XS_W'(half_cl) - XS_W'(nd_cl) + XS_W'(1);
               xe_in    = XS_W'(ocol_ff) + XS_W'(half_cl);
               xl_in    = XS_W'(ocol_ff) - XS_W'(half_cl);
               ix_in    = XS_W'(ocol_ff) - XS_W'(half_cl) - XS_W'(nd_cl) + XS_W'(1);
               iy_in    = '0;
               islot_in = (int'(oslot_ff) >= int'(half_cl)) ?
                          RK_W'(int'(oslot_ff) - int'(half_cl)) :
                          RK_W'(int'(oslot_ff) + ROWS_KEPT - int'(half_cl));
               drain_in = '0;
               sd_in    = '0;
               bdisp_in = '0;
               found_in = 1'b0;
               state_in = interior_in ? ST_ISSUE : ST_FIN;
            end
         end
         ST_ISSUE: begin
            flag1_in = (ix_ff >= xl_ff);
            if (ix_ff == xe_ff) begin
               ix_in    = xs_ff;
               iy_in    = iy_ff + RK_W'(1);
               islot_in = (int'(islot_ff) == ROWS_KEPT - 1) ? '0 : islot_ff + RK_W'(1);
               if (int'(iy_ff) == 2 * int'(half_cl)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               ix_in = ix_ff + XS_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) begin
               best_in  = limit_ff;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.shift = 1'b1;
            if (($signed(XS_W'(sd_ff)) <= xl_ff) && (acc_q[0] < best_ff)) begin
               best_in  = acc_q[0];
               bdisp_in = sd_ff;
               found_in = 1'b1;
            end
            if (int'(sd_ff) == int'(nd_cl) - 1) begin
               state_in = ST_FIN;
            end else begin
               sd_in = sd_ff + D_W'(1);
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_disp_in  = found_ff ? 6'(bdisp_ff) : 6'd0;
               rsp_row_in   = 12'(cur_row_ff);
               rsp_col_in   = 10'(cur_col_ff);
               rsp_int_in   = interior_ff;
               rsp_match_in = found_ff;
               rsp_end_in   = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH:  wreg_in    = csr_data[10:0];
            REG_HEIGHT: hreg_in    = csr_data[12:0];
            REG_HALF:   halfreg_in = csr_data[2:0];
            REG_DISP:   ndreg_in   = csr_data[6:0];
            REG_LIMIT:  limreg_in  = csr_data;
            default: ;
         endcase
         pend_in  = '0;
         col_in   = '0;
         row_in   = '0;
         rslot_in = '0;
         ocol_in  = '0;
         orow_in  = '0;
         oslot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wreg_ff      <= RST_WIDTH;
         hreg_ff      <= RST_HEIGHT;
         halfreg_ff   <= RST_HALF;
         ndreg_ff     <= RST_DISP;
         limreg_ff    <= RST_LIMIT;
         pend_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rslot_ff     <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         oslot_ff     <= '0;
         flag1_ff     <= 1'b0;
         flag2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wreg_ff      <= wreg_in;
         hreg_ff      <= hreg_in;
         halfreg_ff   <= halfreg_in;
         ndreg_ff     <= ndreg_in;
         limreg_ff    <= limreg_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rslot_ff     <= rslot_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         oslot_ff     <= oslot_in;
         flag1_ff     <= flag1_in;
         flag2_ff     <= flag1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_sq_ff   <= side_sq_in;
      limit_ff     <= limit_in;
      lag_ff       <= lag_in;
      cur_col_ff   <= cur_col_in;
      cur_row_ff   <= cur_row_in;
      interior_ff  <= interior_in;
      last_ff      <= last_in;
      xs_ff        <= xs_in;
      xe_ff        <= xe_in;
      xl_ff        <= xl_in;
      ix_ff        <= ix_in;
      iy_ff        <= iy_in;
      islot_ff     <= islot_in;
      left_ff      <= ram_left_q;
      drain_ff     <= drain_in;
      sd_ff        <= sd_in;
      bdisp_ff     <= bdisp_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      rsp_disp_ff  <= rsp_disp_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_int_ff   <= rsp_int_in;
      rsp_match_ff <= rsp_match_in;
      rsp_end_ff   <= rsp_end_in;
   end

   sdl_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_left_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_left_pixel),
      .rd_addr (rd_addr),
      .rd_data (ram_left_q)
   );

   sdl_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_right_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_right_pixel),
      .rd_addr (rd_addr),
      .rd_data (ram_right_q)
   );

   // cell d sees the right pixel d columns to the left of the shared left pixel
   cell_ctl_type ctl_q;
   always_comb begin
      ctl_q      = ctl;
      ctl_q.take = flag2_ff;
   end

   for (genvar d = 0; d < MAX_DISP; d++) begin : g_cell
      sdl_cell #(.ACC_W(ACC_W)) u_cell (
         .clock     (clock),
         .ctl       (ctl_q),
         .left_pix  (left_ff),
         .right_in  ((d == 0) ? ram_right_q : right_q[(d == 0) ? 0 : d - 1]),
         .right_out (right_q[d]),
         .acc_in    ((d == MAX_DISP - 1) ? '0 : acc_q[(d == MAX_DISP - 1) ? d : d + 1]),
         .acc_out   (acc_q[d])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_disparity   = rsp_disp_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_interior    = rsp_int_ff;
   assign rsp_match_found = rsp_match_ff;
   assign rsp_frame_end   = rsp_end_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sdl_ram.sv -----
`default_nettype none

module sdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sdl_cell.sv -----
`default_nettype none

module sdl_cell #(
   parameter int ACC_W = 24
) (
   input  wire                        clock,
   input  wire sdl_pkg::cell_ctl_type ctl,
   input  wire [7:0]                  left_pix,
   input  wire [7:0]                  right_in,
   output logic [7:0]                 right_out,
   input  wire [ACC_W-1:0]            acc_in,
   output logic [ACC_W-1:0]           acc_out
);
   import sdl_pkg::*;

   logic [7:0]       right_ff;
   logic [15:0]      sq_ff;
   logic [15:0]      sq_in;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in_next;
   logic [7:0]       ad;

   always_comb begin
      ad    = (left_pix > right_ff) ? (left_pix - right_ff) : (right_ff - left_pix);
      sq_in = ctl.take ? (16'(ad) * 16'(ad)) : 16'd0;
      if (ctl.clear) begin
         acc_in_next = '0;
      end else if (ctl.shift) begin
         acc_in_next = acc_in;
      end else begin
         acc_in_next = acc_ff + ACC_W'(sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      right_ff <= right_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in_next;
   end

   assign right_out = right_ff;
   assign acc_out   = acc_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sdl_checker.sv -----
`default_nettype none

module sdl_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [5:0]                    rsp_disparity,
   input wire [11:0]                   rsp_out_row,
   input wire [9:0]                    rsp_out_col,
   input wire                          rsp_interior,
   input wire                          rsp_match_found
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_interior) |-> (rsp_disparity == 6'd0 && !rsp_match_found))
      else $error("border request carries a disparity or a match");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_match_found) |-> (rsp_disparity == 6'd0))
      else $error("no match but non-zero disparity");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_disparity) &&
                                    $stable(rsp_out_col) && $stable(rsp_out_row)))
      else $error("stalled result changed");

endmodule

bind ssd_stereo_disparity_left sdl_checker u_checker (.*);

`default_nettype wire
